// ===== hdl/vn3_pkg.sv =====
// vn3_pkg: shared constants and types for the 3d vector normalizer
// no dependencies
package vn3_pkg;
  localparam int CW = 16;              // component width, q8.8
  localparam int UF = 14;              // unit fraction bits
  localparam int UW = UF + 2;          // unit output width
  localparam int AW = CW;              // magnitude of a component
  localparam int SW = 2 * AW + 2;      // sum of three squares
  localparam int RW = SW / 2;          // root width
  localparam int NW = AW + UF;         // dividend width
  localparam int QW = NW;              // quotient width

  typedef struct packed {
    logic [AW-1:0] a;
    logic          neg;
  } comp_t;
endpackage

// ===== hdl/vn3_sqrt_cell.sv =====
// vn3_sqrt_cell: one bit step of a restoring square root, registered
// depends on vn3_pkg
module vn3_sqrt_cell import vn3_pkg::*; (
  input  logic            clk,
  input  logic [RW-1:0]   bit_i,
  input  logic [SW-1:0]   sum_i,
  input  logic [RW-1:0]   root_i,
  input  comp_t           c_i [3],
  output logic [SW-1:0]   sum_o,
  output logic [RW-1:0]   root_o,
  output comp_t           c_o [3]
);
  logic [RW-1:0] t;
  logic [SW-1:0] sq;
  logic [SW-1:0] sum_r;
  logic [RW-1:0] root_r;
  comp_t         c_r [3];

  assign t  = root_i | bit_i;
  assign sq = SW'(t) * SW'(t);

  always_ff @(posedge clk) begin
    sum_r  <= sum_i;
    root_r <= (sq <= sum_i) ? t : root_i;
    c_r    <= c_i;
  end

  assign sum_o  = sum_r;
  assign root_o = root_r;
  assign c_o    = c_r;
endmodule

// ===== hdl/vn3_div_cell.sv =====
// vn3_div_cell: one quotient bit of three parallel restoring divisions
// depends on vn3_pkg
module vn3_div_cell import vn3_pkg::*; (
  input  logic            clk,
  input  logic [$clog2(QW)-1:0] pos_i,
  input  logic [RW-1:0]   den_i,
  input  logic [NW-1:0]   rem_i [3],
  input  logic [QW-1:0]   q_i [3],
  input  logic [2:0]      neg_i,
  output logic [RW-1:0]   den_o,
  output logic [NW-1:0]   rem_o [3],
  output logic [QW-1:0]   q_o [3],
  output logic [2:0]      neg_o
);
  logic [NW+RW-1:0] trial [3];
  logic [RW-1:0]    den_r;
  logic [NW-1:0]    rem_r [3];
  logic [QW-1:0]    q_r [3];
  logic [2:0]       neg_r;

  always_comb begin
    for (int i = 0; i < 3; i++)
      trial[i] = (NW+RW)'(den_i) << pos_i;
  end

  always_ff @(posedge clk) begin
    den_r <= den_i;
    neg_r <= neg_i;
    for (int i = 0; i < 3; i++) begin
      if ((NW+RW)'(rem_i[i]) >= trial[i]) begin
        rem_r[i] <= NW'((NW+RW)'(rem_i[i]) - trial[i]);
        q_r[i]   <= q_i[i] | (QW'(1) << pos_i);
      end else begin
        rem_r[i] <= rem_i[i];
        q_r[i]   <= q_i[i];
      end
    end
  end

  assign den_o = den_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign neg_o = neg_r;
endmodule

// ===== hdl/vector_normalize_3d.sv =====
// vector_normalize_3d: top level, squares, sqrt cell row, divider cell row
// depends on vn3_pkg, vn3_sqrt_cell, vn3_div_cell
// One word in per cycle, one word out per cycle; busy is always low. The
// pipeline is the input stage, a squares stage, 17 root cells, 30 quotient
// cells and an output stage. out_valid pulses once per word and cannot be
// stalled.
module vector_normalize_3d import vn3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_x_in,
  input  logic signed [CW-1:0] in_y_in,
  input  logic signed [CW-1:0] in_z_in,
  output logic                 out_valid,
  output logic signed [UW-1:0] out_x_unit,
  output logic signed [UW-1:0] out_y_unit,
  output logic signed [UW-1:0] out_z_unit,
  output logic [CW-1:0]        out_magnitude,
  output logic                 out_zero_length
);
  localparam int LAT = RW + QW + 3;

  logic [LAT-1:0] vld_r;
  comp_t          c0_r [3];
  logic [2*AW-1:0] c0_sq [3];
  logic [SW-1:0]  sum_r;
  comp_t          c1_r [3];

  logic [SW-1:0]  s_sum  [RW+1];
  logic [RW-1:0]  s_root [RW+1];
  comp_t          s_c    [RW+1][3];

  logic [RW-1:0]  d_den [QW+1];
  logic [NW-1:0]  d_rem [QW+1][3];
  logic [QW-1:0]  d_q   [QW+1][3];
  logic [2:0]     d_neg [QW+1];

  logic signed [UW-1:0] ux_r, uy_r, uz_r;
  logic [CW-1:0]  mag_r;
  logic           zl_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], start};
  end

  function automatic comp_t mk_comp(input logic [CW-1:0] v);
    comp_t c;
    c.neg = v[CW-1];
    c.a   = v[CW-1] ? AW'(-v) : v;
    return c;
  endfunction

  // input stage: sign and magnitude
  always_ff @(posedge clk) begin
    c0_r[0] <= mk_comp(in_x_in);
    c0_r[1] <= mk_comp(in_y_in);
    c0_r[2] <= mk_comp(in_z_in);
  end

  assign c0_sq[0] = {AW'(0), c0_r[0].a} * {AW'(0), c0_r[0].a};
  assign c0_sq[1] = {AW'(0), c0_r[1].a} * {AW'(0), c0_r[1].a};
  assign c0_sq[2] = {AW'(0), c0_r[2].a} * {AW'(0), c0_r[2].a};

  // squares stage
  always_ff @(posedge clk) begin
    sum_r <= SW'(c0_sq[0]) + SW'(c0_sq[1]) + SW'(c0_sq[2]);
    c1_r  <= c0_r;
  end

  assign s_sum[0]  = sum_r;
  assign s_root[0] = '0;
  assign s_c[0]    = c1_r;

  genvar g;
  generate
    for (g = 0; g < RW; g++) begin : g_sq
      vn3_sqrt_cell u_cell (
        .clk    (clk),
        .bit_i  (RW'(1) << (RW - 1 - g)),
        .sum_i  (s_sum[g]),
        .root_i (s_root[g]),
        .c_i    (s_c[g]),
        .sum_o  (s_sum[g+1]),
        .root_o (s_root[g+1]),
        .c_o    (s_c[g+1])
      );
    end
  endgenerate

  assign d_den[0] = s_root[RW];
  generate
    for (g = 0; g < 3; g++) begin : g_in
      assign d_rem[0][g] = NW'(s_c[RW][g].a) << UF;
      assign d_q[0][g]   = '0;
      assign d_neg[0][g] = s_c[RW][g].neg;
    end
  endgenerate

  generate
    for (g = 0; g < QW; g++) begin : g_dv
      vn3_div_cell u_cell (
        .clk   (clk),
        .pos_i ($clog2(QW)'(QW - 1 - g)),
        .den_i (d_den[g]),
        .rem_i (d_rem[g]),
        .q_i   (d_q[g]),
        .neg_i (d_neg[g]),
        .den_o (d_den[g+1]),
        .rem_o (d_rem[g+1]),
        .q_o   (d_q[g+1]),
        .neg_o (d_neg[g+1])
      );
    end
  endgenerate

  function automatic logic [UW-1:0] sat(input logic [QW-1:0] q, input logic n);
    logic [UW-1:0] m;
    m = (q > QW'(1 << UF)) ? UW'(1 << UF) : UW'(q);
    return n ? UW'(-m) : m;
  endfunction

  // output stage
  always_ff @(posedge clk) begin
    zl_r  <= (d_den[QW] == '0);
    mag_r <= CW'(d_den[QW]);
    if (d_den[QW] == '0) begin
      ux_r <= '0;
      uy_r <= '0;
      uz_r <= '0;
    end else begin
      ux_r <= sat(d_q[QW][0], d_neg[QW][0]);
      uy_r <= sat(d_q[QW][1], d_neg[QW][1]);
      uz_r <= sat(d_q[QW][2], d_neg[QW][2]);
    end
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_x_unit      = ux_r;
  assign out_y_unit      = uy_r;
  assign out_z_unit      = uz_r;
  assign out_magnitude   = mag_r;
  assign out_zero_length = zl_r;
endmodule
